// ----- hw/rtl/toec_pkg.sv -----
// ============================================================================
// toec_pkg - shared types and constants of the two-operand calculator
// Operand and fraction widths, character codes, parser phases, status codes,
// and the command and status bundles between the controller and the datapath.
// ============================================================================
package toec_pkg;

    localparam int OPERAND_BITS   = 31;
    localparam int FRACTION_BITS  = 20;
    localparam int DIVIDEND_BITS  = OPERAND_BITS + FRACTION_BITS;
    localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);
    localparam int ACC_BITS       = OPERAND_BITS + 4;
    localparam int PRODUCT_BITS   = 2 * OPERAND_BITS;
    localparam int VALUE_BITS     = 64;
    localparam int CHAR_BITS      = 8;
    localparam int STATUS_BITS    = 3;

    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_SYNTAX   = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_MODZERO  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_PREOP  = 3'd2,
        PH_POSTOP = 3'd3,
        PH_SECOND = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIVIDE,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic char_load;
        logic eval;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic newline;
        logic div_needed;
        logic div_last;
        logic out_free;
    } dp_stat_t;

    function automatic op_t op_of(input logic [CHAR_BITS-1:0] ch);
        op_t op;
        case (ch)
            CH_PLUS:    op = OP_ADD;
            CH_MINUS:   op = OP_SUB;
            CH_STAR:    op = OP_MUL;
            CH_SLASH:   op = OP_DIV;
            CH_PERCENT: op = OP_MOD;
            default:    op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ----- hw/rtl/toec_divider.sv -----
// ============================================================================
// toec_divider - restoring divider, one quotient bit per cycle while step is high
// Loads the dividend on start and runs DIVIDEND_BITS steps; the quotient and
// the remainder are valid after the last step.
// ============================================================================
module toec_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  step,
    input  logic [toec_pkg::DIVIDEND_BITS-1:0]    dividend,
    input  logic [toec_pkg::OPERAND_BITS-1:0]     divisor,
    output logic [toec_pkg::DIVIDEND_BITS-1:0]    quotient,
    output logic [toec_pkg::OPERAND_BITS-1:0]     remainder,
    output logic                                  last
);
    import toec_pkg::*;

    logic [DIVIDEND_BITS-1:0]  quo_reg, quo_next;
    logic [OPERAND_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_COUNT_BITS-1:0] count_reg, count_next;
    logic [OPERAND_BITS:0]     shifted;
    logic [OPERAND_BITS:0]     divisor_ext;
    logic [OPERAND_BITS:0]     diff;
    logic                      ge;

    assign shifted     = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign divisor_ext = {1'b0, divisor};
    assign ge          = shifted >= divisor_ext;
    assign diff        = shifted - divisor_ext;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = DIV_COUNT_BITS'(DIVIDEND_BITS);
        end
        else if (step)
        begin
            quo_next   = {quo_reg[DIVIDEND_BITS-2:0], ge};
            rem_next   = ge ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign last      = count_reg == DIV_COUNT_BITS'(1);

endmodule

// ----- hw/rtl/toec_datapath.sv -----
// ============================================================================
// toec_datapath - line parser, operand registers and arithmetic
// Accumulates the operands and the operator, evaluates the line, drives the
// shared divider and holds the result beat in the output register.
// ============================================================================
module toec_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  toec_pkg::dp_cmd_t                   cmd,
    output toec_pkg::dp_stat_t                  stat,
    input  logic [toec_pkg::CHAR_BITS-1:0]      character,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [toec_pkg::STATUS_BITS-1:0]    status,
    output logic signed [toec_pkg::VALUE_BITS-1:0] value,
    output logic                                is_fractional
);
    import toec_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [OPERAND_BITS-1:0] first_reg, first_next;
    logic [OPERAND_BITS-1:0] second_reg, second_next;
    op_t                     op_reg, op_next;
    logic                    first_seen_reg, first_seen_next;
    logic                    second_seen_reg, second_seen_next;
    logic                    bad_reg, bad_next;
    logic                    ovf_reg, ovf_next;

    status_t                 eval_status_reg;
    logic [VALUE_BITS-1:0]   result_reg;
    logic                    out_valid_reg;
    status_t                 status_out_reg;
    logic [VALUE_BITS-1:0]   value_out_reg;
    logic                    frac_out_reg;

    logic                    digit;
    logic                    space;
    op_t                     char_op;
    logic [OPERAND_BITS-1:0] acc_src;
    logic [ACC_BITS-1:0]     acc_wide;
    logic [ACC_BITS-1:0]     acc_sum;
    logic                    acc_fits;
    status_t                 status_eval;
    logic [PRODUCT_BITS-1:0] product;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVIDEND_BITS-1:0] quotient;
    logic [OPERAND_BITS-1:0] remainder;
    logic                    div_last;

    assign digit   = (character >= CH_ZERO) && (character <= CH_NINE);
    assign space   = character == CH_SPACE;
    assign char_op = op_of(character);

    // one shared decimal accumulator: acc * 10 + digit
    assign acc_src  = (phase_reg == PH_LEAD || phase_reg == PH_FIRST) ? first_reg : second_reg;
    assign acc_wide = ACC_BITS'(acc_src);
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + ACC_BITS'(character[3:0]);
    assign acc_fits = acc_sum[ACC_BITS-1:OPERAND_BITS] == '0;

    always_comb
    begin
        phase_next       = phase_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        op_next          = op_reg;
        first_seen_next  = first_seen_reg;
        second_seen_next = second_seen_reg;
        bad_next         = bad_reg;
        ovf_next         = ovf_reg;
        if (cmd.char_load)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (space)
                    begin
                    end
                    else if (digit)
                    begin
                        first_seen_next = 1'b1;
                        phase_next      = PH_FIRST;
                        if (acc_fits) first_next = acc_sum[OPERAND_BITS-1:0];
                        else          ovf_next   = 1'b1;
                    end
                    else if (char_op != OP_NONE)
                    begin
                        op_next    = char_op;
                        phase_next = PH_POSTOP;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                PH_FIRST:
                begin
                    if (digit)
                    begin
                        if (acc_fits) first_next = acc_sum[OPERAND_BITS-1:0];
                        else          ovf_next   = 1'b1;
                    end
                    else if (space)
                    begin
                        phase_next = PH_PREOP;
                    end
                    else if (char_op != OP_NONE)
                    begin
                        op_next    = char_op;
                        phase_next = PH_POSTOP;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                PH_PREOP:
                begin
                    if (space)
                    begin
                    end
                    else if (char_op != OP_NONE)
                    begin
                        op_next    = char_op;
                        phase_next = PH_POSTOP;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                PH_POSTOP:
                begin
                    if (space)
                    begin
                    end
                    else if (digit)
                    begin
                        second_seen_next = 1'b1;
                        phase_next       = PH_SECOND;
                        if (acc_fits) second_next = acc_sum[OPERAND_BITS-1:0];
                        else          ovf_next    = 1'b1;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                PH_SECOND:
                begin
                    if (digit)
                    begin
                        if (acc_fits) second_next = acc_sum[OPERAND_BITS-1:0];
                        else          ovf_next    = 1'b1;
                    end
                    else if (space)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                default:
                begin
                    if (!space)
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
            endcase
        end
        if (cmd.finish)
        begin
            phase_next       = PH_LEAD;
            first_next       = '0;
            second_next      = '0;
            op_next          = OP_NONE;
            first_seen_next  = 1'b0;
            second_seen_next = 1'b0;
            bad_next         = 1'b0;
            ovf_next         = 1'b0;
        end
    end

    always_comb
    begin
        if (bad_reg || !first_seen_reg || !second_seen_reg || op_reg == OP_NONE)
            status_eval = ST_SYNTAX;
        else if (ovf_reg)
            status_eval = ST_OVERFLOW;
        else if (op_reg == OP_DIV && second_reg == '0)
            status_eval = ST_DIVZERO;
        else if (op_reg == OP_MOD && second_reg == '0)
            status_eval = ST_MODZERO;
        else
            status_eval = ST_OK;
    end

    assign product  = first_reg * second_reg;
    assign dividend = (op_reg == OP_DIV) ? (DIVIDEND_BITS'(first_reg) << FRACTION_BITS)
                                         : DIVIDEND_BITS'(first_reg);

    toec_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.eval),
        .step      (cmd.div_step),
        .dividend  (dividend),
        .divisor   (second_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .last      (div_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            first_reg       <= '0;
            second_reg      <= '0;
            op_reg          <= OP_NONE;
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
            bad_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            op_reg          <= op_next;
            first_seen_reg  <= first_seen_next;
            second_seen_reg <= second_seen_next;
            bad_reg         <= bad_next;
            ovf_reg         <= ovf_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            eval_status_reg <= status_eval;
            case (op_reg)
                OP_ADD:  result_reg <= VALUE_BITS'(first_reg) + VALUE_BITS'(second_reg);
                OP_SUB:  result_reg <= VALUE_BITS'(first_reg) - VALUE_BITS'(second_reg);
                OP_MUL:  result_reg <= VALUE_BITS'(product);
                default: result_reg <= '0;
            endcase
        end
        if (cmd.finish)
        begin
            status_out_reg <= eval_status_reg;
            frac_out_reg   <= (eval_status_reg == ST_OK) && (op_reg == OP_DIV);
            if (eval_status_reg != ST_OK)
                value_out_reg <= '0;
            else if (op_reg == OP_DIV)
                value_out_reg <= VALUE_BITS'(quotient);
            else if (op_reg == OP_MOD)
                value_out_reg <= VALUE_BITS'(remainder);
            else
                value_out_reg <= result_reg;
        end
    end

    assign stat.newline    = character == CH_NEWLINE;
    assign stat.div_needed = (status_eval == ST_OK) && (op_reg == OP_DIV || op_reg == OP_MOD);
    assign stat.div_last   = div_last;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = status_out_reg;
    assign value         = value_out_reg;
    assign is_fractional = frac_out_reg;

    a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result beat overwritten before it was taken");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_out_reg != ST_OK |-> value_out_reg == '0 && !frac_out_reg)
        else $error("failed line carries a nonzero result");

    a_no_newline_parse: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.char_load |-> !stat.newline)
        else $error("newline fed to the parser");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> phase_reg == PH_LEAD && !first_seen_reg && !bad_reg)
        else $error("line state not cleared with the result");

endmodule

// ----- hw/rtl/toec_ctrl.sv -----
// ============================================================================
// toec_ctrl - sequencing state machine of the calculator
// Takes characters while idle; on newline runs evaluation, the divider steps
// when needed, and hands the result to the output register.
// ============================================================================
module toec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  toec_pkg::dp_stat_t  stat,
    output toec_pkg::dp_cmd_t   cmd
);
    import toec_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.newline)
                        state_next = S_EVAL;
                    else
                        cmd.char_load = 1'b1;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.div_needed ? S_DIVIDE : S_FINISH;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/two_operand_expression_calculator.sv -----
// ============================================================================
// two_operand_expression_calculator - ASCII line calculator, two operands
// Parses "number op number" a character per beat and returns one result beat
// per newline.
// ============================================================================
// Every character other than newline is loaded straight into the parser. A
// newline moves through an evaluation state and then an output-load state. A
// well-formed / or % with a nonzero divisor also runs the restoring divider
// between the two, one quotient bit per cycle. The output-load state waits
// while an earlier result beat is still held. No input is taken during any
// of this. The result beat sits in an output register, so characters of the
// next line are taken while it waits.
module two_operand_expression_calculator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [toec_pkg::CHAR_BITS-1:0]         character,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [toec_pkg::STATUS_BITS-1:0]       status,
    output logic signed [toec_pkg::VALUE_BITS-1:0] value,
    output logic                                   is_fractional
);
    import toec_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    toec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    toec_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .character     (character),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .value         (value),
        .is_fractional (is_fractional)
    );

endmodule
